>>> design/sflm_pkg.sv
// sflm_pkg: shared constants for the stereo frame level meter
// used by sflm_root and stereo_frame_level_meter; no dependencies
package sflm_pkg;

  localparam int WORD_W        = 32;   // i2s word width
  localparam int SAMPLE_SHIFT  = 8;    // word to 24-bit sample
  localparam int SAMPLE_W      = WORD_W - SAMPLE_SHIFT;
  localparam int SQ_W          = 2 * SAMPLE_W;  // square of sample magnitude
  localparam int ROOT_W        = 24;   // rms result width
  localparam int CNT_OUT_W     = 9;    // width of the count fields
  localparam int FRAME_MAX_DEF = 256;

  localparam logic signed [WORD_W-1:0] MIN_RESET = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] MAX_RESET = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

>>> design/stereo_frame_level_meter.sv
// stereo_frame_level_meter: per-frame level statistics; depends on sflm_pkg and sflm_root
// result: valid after a frame-closing transfer, once both channel roots are done and
//   the output register is free; SUM_W = 48 + clog2(FRAME_MAX); other pairs give no result
// input: stalled while a pair is squared and summed on the shared squarer, so a new pair
//   waits for the last; a frame-closing pair also holds it through both roots and any output stall
// reset: rst_ni async active low, statistics return to their empty-frame values
module stereo_frame_level_meter
  import sflm_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [WORD_W-1:0] left_word_i,
  input  logic signed [WORD_W-1:0] right_word_i,
  input  logic                     frame_last_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] lch_min_o,
  output logic signed [WORD_W-1:0] lch_max_o,
  output logic signed [WORD_W-1:0] rch_min_o,
  output logic signed [WORD_W-1:0] rch_max_o,
  output logic [CNT_OUT_W-1:0]     lch_nonzero_o,
  output logic [CNT_OUT_W-1:0]     rch_nonzero_o,
  output logic [CNT_OUT_W-1:0]     pair_total_o,
  output logic [ROOT_W-1:0]        lch_rms_o,
  output logic [ROOT_W-1:0]        rch_rms_o
);

  // counters hold FRAME_MAX exactly; the result fields take the low bits
  localparam int CW    = ($clog2(FRAME_MAX + 1) > CNT_OUT_W) ?
                         $clog2(FRAME_MAX + 1) : CNT_OUT_W;
  localparam int SUM_W = SQ_W + $clog2(FRAME_MAX);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_L  = 3'd1;  // square left sample
  localparam logic [2:0] S_MUL_R  = 3'd2;  // add left square, square right
  localparam logic [2:0] S_ACC_R  = 3'd3;  // add right square
  localparam logic [2:0] S_ROOT_L = 3'd4;  // left mean root running
  localparam logic [2:0] S_ROOT_R = 3'd5;  // right mean root running
  localparam logic [2:0] S_HOLD   = 3'd6;  // wait for a free output register

  logic [2:0] state_q, state_d;

  // running frame statistics
  logic signed [WORD_W-1:0] lmin_q, lmin_d, lmax_q, lmax_d;
  logic signed [WORD_W-1:0] rmin_q, rmin_d, rmax_q, rmax_d;
  logic [CW-1:0]            lnz_q, lnz_d, rnz_q, rnz_d, pairs_q, pairs_d;
  logic [SUM_W-1:0]         lsum_q, lsum_d, rsum_q, rsum_d;
  logic                     end_q, end_d;

  // samples of the current pair and the squarer output
  logic signed [SAMPLE_W-1:0] lsamp_q, lsamp_d, rsamp_q, rsamp_d;
  logic [SQ_W-1:0]            prod_q, prod_d;
  logic signed [SAMPLE_W-1:0] mul_in;
  logic [SAMPLE_W-1:0]        mag;

  logic [ROOT_W-1:0] lrms_q, lrms_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic signed [WORD_W-1:0] o_lmin_q, o_lmax_q, o_rmin_q, o_rmax_q;
  logic [CNT_OUT_W-1:0]     o_lnz_q, o_rnz_q, o_pairs_q;
  logic [ROOT_W-1:0]        o_lrms_q, o_rrms_q;

  logic             in_xfer, out_load;
  logic [CW-1:0]    pairs_inc;

  // root unit hookup
  logic              ru_start, ru_busy, ru_done;
  logic [SUM_W-1:0]  ru_sum;
  logic [ROOT_W-1:0] ru_root;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_load   = (state_q == S_HOLD) & (~out_valid_q | ~out_stall_i);
  assign pairs_inc  = pairs_q + 1'b1;

  // one shared squarer, magnitude of the 24-bit sample
  always_comb begin
    mul_in = (state_q == S_MUL_L) ? lsamp_q : rsamp_q;
    mag    = mul_in[SAMPLE_W-1] ? SAMPLE_W'(-mul_in) : SAMPLE_W'(mul_in);
  end

  // root requests: left on frame end, right as soon as left is done
  assign ru_start = ((state_q == S_ACC_R) & end_q) | ((state_q == S_ROOT_L) & ru_done);
  assign ru_sum   = (state_q == S_ACC_R) ? lsum_q : rsum_q;

  always_comb begin
    state_d = state_q;
    lmin_d  = lmin_q;
    lmax_d  = lmax_q;
    rmin_d  = rmin_q;
    rmax_d  = rmax_q;
    lnz_d   = lnz_q;
    rnz_d   = rnz_q;
    pairs_d = pairs_q;
    lsum_d  = lsum_q;
    rsum_d  = rsum_q;
    end_d   = end_q;
    lsamp_d = lsamp_q;
    rsamp_d = rsamp_q;
    prod_d  = prod_q;
    lrms_d  = lrms_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          // compare and count stats on the transfer itself
          if (left_word_i < lmin_q) lmin_d = left_word_i;
          if (left_word_i > lmax_q) lmax_d = left_word_i;
          if (right_word_i < rmin_q) rmin_d = right_word_i;
          if (right_word_i > rmax_q) rmax_d = right_word_i;
          if (left_word_i != '0) lnz_d = lnz_q + 1'b1;
          if (right_word_i != '0) rnz_d = rnz_q + 1'b1;
          pairs_d = pairs_inc;
          end_d   = frame_last_i | (pairs_inc == CW'(FRAME_MAX));
          lsamp_d = left_word_i[WORD_W-1:SAMPLE_SHIFT];
          rsamp_d = right_word_i[WORD_W-1:SAMPLE_SHIFT];
          state_d = S_MUL_L;
        end
      end
      S_MUL_L: begin
        prod_d  = mag * mag;
        state_d = S_MUL_R;
      end
      S_MUL_R: begin
        lsum_d  = lsum_q + SUM_W'(prod_q);
        prod_d  = mag * mag;
        state_d = S_ACC_R;
      end
      S_ACC_R: begin
        rsum_d  = rsum_q + SUM_W'(prod_q);
        state_d = end_q ? S_ROOT_L : S_IDLE;
      end
      S_ROOT_L: begin
        if (ru_done) begin
          lrms_d  = ru_root;
          state_d = S_ROOT_R;
        end
      end
      S_ROOT_R: begin
        if (ru_done) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_load) begin
          // result captured, start an empty frame
          lmin_d  = MIN_RESET;
          lmax_d  = MAX_RESET;
          rmin_d  = MIN_RESET;
          rmax_d  = MAX_RESET;
          lnz_d   = '0;
          rnz_d   = '0;
          pairs_d = '0;
          lsum_d  = '0;
          rsum_d  = '0;
          end_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q & ~out_stall_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lmin_q      <= MIN_RESET;
      lmax_q      <= MAX_RESET;
      rmin_q      <= MIN_RESET;
      rmax_q      <= MAX_RESET;
      lnz_q       <= '0;
      rnz_q       <= '0;
      pairs_q     <= '0;
      lsum_q      <= '0;
      rsum_q      <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lmin_q      <= lmin_d;
      lmax_q      <= lmax_d;
      rmin_q      <= rmin_d;
      rmax_q      <= rmax_d;
      lnz_q       <= lnz_d;
      rnz_q       <= rnz_d;
      pairs_q     <= pairs_d;
      lsum_q      <= lsum_d;
      rsum_q      <= rsum_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // data path registers, no reset needed
  always_ff @(posedge clk_i) begin
    lsamp_q <= lsamp_d;
    rsamp_q <= rsamp_d;
    prod_q  <= prod_d;
    lrms_q  <= lrms_d;
    if (out_load) begin
      o_lmin_q  <= lmin_q;
      o_lmax_q  <= lmax_q;
      o_rmin_q  <= rmin_q;
      o_rmax_q  <= rmax_q;
      o_lnz_q   <= lnz_q[CNT_OUT_W-1:0];
      o_rnz_q   <= rnz_q[CNT_OUT_W-1:0];
      o_pairs_q <= pairs_q[CNT_OUT_W-1:0];
      o_lrms_q  <= lrms_q;
      o_rrms_q  <= ru_root;
    end
  end

  // serial divide and root, shared by both channels
  sflm_root #(
    .SUM_W (SUM_W),
    .CNT_W (CW)
  ) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ru_start),
    .sum_i   (ru_sum),
    .count_i (pairs_q),
    .busy_o  (ru_busy),
    .done_o  (ru_done),
    .root_o  (ru_root)
  );

  assign out_valid_o   = out_valid_q;
  assign lch_min_o     = o_lmin_q;
  assign lch_max_o     = o_lmax_q;
  assign rch_min_o     = o_rmin_q;
  assign rch_max_o     = o_rmax_q;
  assign lch_nonzero_o = o_lnz_q;
  assign rch_nonzero_o = o_rnz_q;
  assign pair_total_o  = o_pairs_q;
  assign lch_rms_o     = o_lrms_q;
  assign rch_rms_o     = o_rrms_q;

  // root unit only runs while the sequencer waits for it
  a_root_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ru_busy |-> (state_q == S_ROOT_L || state_q == S_ROOT_R))
    else $error("root unit busy outside the root states");

  // a new result only comes out of the hold state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_HOLD)
    else $error("result raised without a completed frame");

  // the pair count never runs past the frame limit
  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pairs_q <= CW'(FRAME_MAX))
    else $error("pair count beyond frame limit");

  // a frame that reached the limit is always closed
  a_limit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_L && pairs_q == CW'(FRAME_MAX)) |-> end_q)
    else $error("full frame not marked as ended");

endmodule

>>> design/sflm_root.sv
// sflm_root: floor(sqrt(floor(sum / count))), one bit per cycle
// restoring divide then digit-by-digit root on one shared subtractor; uses sflm_pkg
module sflm_root
  import sflm_pkg::*;
#(
  parameter int SUM_W = 56,
  parameter int CNT_W = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  sum_i,
  input  logic [CNT_W-1:0]  count_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int RW     = (CNT_W + 1 > ROOT_W + 4) ? CNT_W + 1 : ROOT_W + 4;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_SQRT = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  num_q, num_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [SQ_W-1:0]   rad_q, rad_d;
  logic [ROOT_W-1:0] root_q, root_d;

  logic [RW-1:0]     rem_sh, sub_b, rem_nx;
  logic [RW:0]       diff;
  logic              take;
  logic [SUM_W-1:0]  quo;

  // shared subtract and compare
  always_comb begin
    if (phase_q == PH_DIV) begin
      rem_sh = {rem_q[RW-2:0], num_q[SUM_W-1]};
      sub_b  = RW'(den_q);
    end else begin
      rem_sh = {rem_q[RW-3:0], rad_q[SQ_W-1 -: 2]};
      sub_b  = RW'({root_q, 2'b01});
    end
    diff   = {1'b0, rem_sh} - {1'b0, sub_b};
    take   = ~diff[RW];
    rem_nx = take ? diff[RW-1:0] : rem_sh;
    quo    = {num_q[SUM_W-2:0], take};
  end

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    step_d  = step_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    rad_d   = rad_q;
    root_d  = root_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          num_d   = sum_i;
          den_d   = count_i;
          rem_d   = '0;
          step_d  = STEP_W'(SUM_W - 1);
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        num_d = quo;
        rem_d = rem_nx;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          rad_d   = quo[SQ_W-1:0];
          rem_d   = '0;
          root_d  = '0;
          step_d  = STEP_W'(ROOT_W - 1);
          phase_d = PH_SQRT;
        end
      end
      PH_SQRT: begin
        rem_d  = rem_nx;
        root_d = {root_q[ROOT_W-2:0], take};
        rad_d  = rad_q << 2;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    root_q <= root_d;
  end

  assign busy_o = (phase_q != PH_IDLE);
  assign done_o = done_q;
  assign root_o = root_q;

endmodule
